// File: hdl/ipatc_pkg.sv
// ----------------------------------------------------------------------------
// ipatc_pkg
// shared types and constants for the ip address text classifier
// ----------------------------------------------------------------------------
package ipatc_pkg;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;

  // result codes
  localparam logic [1:0] CLASS_IPV4    = 2'd0;
  localparam logic [1:0] CLASS_IPV6    = 2'd1;
  localparam logic [1:0] CLASS_NEITHER = 2'd2;

  // ipv4 / ipv6 form limits
  localparam logic [1:0] V4_LAST_DOT    = 2'd3;
  localparam logic [1:0] V4_MAX_DIGITS  = 2'd3;
  localparam logic [2:0] V6_LAST_COLON  = 3'd7;
  localparam logic [2:0] V6_MAX_DIGITS  = 3'd4;
  localparam logic [11:0] V4_OCTET_MAX  = 12'd255;

  // token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one classified character
  typedef struct packed {
    logic       is_digit;
    logic       is_hex;
    logic       is_dot;
    logic       is_colon;
    logic [3:0] digit;
    logic       last;
  } token_t;

endpackage

// File: hdl/ipatc_front.sv
// ----------------------------------------------------------------------------
// ipatc_front
// character classifier, turns an input beat into a token for the queue
// ----------------------------------------------------------------------------
module ipatc_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_text_char,
  input  logic            in_is_final,
  output logic            push,
  output ipatc_pkg::token_t push_tok,
  input  logic            q_full
);
  import ipatc_pkg::*;

  logic dec, lc, uc;

  always_comb begin
    dec = (in_text_char >= CH_ZERO) && (in_text_char <= CH_NINE);
    lc  = (in_text_char >= CH_LC_A) && (in_text_char <= CH_LC_F);
    uc  = (in_text_char >= CH_UC_A) && (in_text_char <= CH_UC_F);
    push_tok.is_digit = dec;
    push_tok.is_hex   = dec | lc | uc;
    push_tok.is_dot   = (in_text_char == CH_DOT);
    push_tok.is_colon = (in_text_char == CH_COLON);
    push_tok.digit    = in_text_char[3:0];
    push_tok.last     = in_is_final;
  end

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

endmodule

// File: hdl/ipatc_queue.sv
// ----------------------------------------------------------------------------
// ipatc_queue
// short token fifo, push and pop in the same cycle allowed
// ----------------------------------------------------------------------------
module ipatc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ipatc_pkg::token_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              tok_valid,
  output ipatc_pkg::token_t tok
);
  import ipatc_pkg::*;

  token_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QDEPTH));
  assign tok_valid = (count_r != '0);
  assign tok       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// File: hdl/ipatc_back.sv
// ----------------------------------------------------------------------------
// ipatc_back
// ipv4 and ipv6 recognizers plus the result register
// ----------------------------------------------------------------------------
module ipatc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  input  ipatc_pkg::token_t tok,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_address_class
);
  import ipatc_pkg::*;

  logic       v4_alive_r, v4_alive_nxt;
  logic [1:0] v4_dot_r, v4_dot_nxt;
  logic [1:0] v4_dig_r, v4_dig_nxt;
  logic [7:0] v4_oct_r, v4_oct_nxt;
  logic       v4_lz_r, v4_lz_nxt;
  logic       v6_alive_r, v6_alive_nxt;
  logic [2:0] v6_colon_r, v6_colon_nxt;
  logic [2:0] v6_dig_r, v6_dig_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_class_r, out_class_nxt;
  logic [11:0] oct_next;
  logic [1:0]  cls;

  assign pop = tok_valid & (~tok.last | ~out_valid_r | ~out_stall);
  assign out_valid         = out_valid_r;
  assign out_address_class = out_class_r;

  // octet * 10 + digit
  assign oct_next = {1'b0, v4_oct_r, 3'b000} + {3'b000, v4_oct_r, 1'b0}
                  + {8'd0, tok.digit};

  always_comb begin
    v4_alive_nxt = v4_alive_r;
    v4_dot_nxt   = v4_dot_r;
    v4_dig_nxt   = v4_dig_r;
    v4_oct_nxt   = v4_oct_r;
    v4_lz_nxt    = v4_lz_r;
    v6_alive_nxt = v6_alive_r;
    v6_colon_nxt = v6_colon_r;
    v6_dig_nxt   = v6_dig_r;

    // ipv4
    if (v4_alive_r) begin
      if (tok.is_digit) begin
        if (v4_dig_r == V4_MAX_DIGITS || v4_lz_r || oct_next > V4_OCTET_MAX) begin
          v4_alive_nxt = 1'b0;
        end else begin
          if (v4_dig_r == 2'd0 && tok.digit == 4'd0) begin
            v4_lz_nxt = 1'b1;
          end
          v4_oct_nxt = oct_next[7:0];
          v4_dig_nxt = v4_dig_r + 1'b1;
        end
      end else if (tok.is_dot) begin
        if (v4_dig_r == 2'd0 || v4_dot_r == V4_LAST_DOT) begin
          v4_alive_nxt = 1'b0;
        end else begin
          v4_dot_nxt = v4_dot_r + 1'b1;
          v4_dig_nxt = 2'd0;
          v4_oct_nxt = 8'd0;
          v4_lz_nxt  = 1'b0;
        end
      end else begin
        v4_alive_nxt = 1'b0;
      end
    end

    // ipv6
    if (v6_alive_r) begin
      if (tok.is_hex) begin
        if (v6_dig_r == V6_MAX_DIGITS) begin
          v6_alive_nxt = 1'b0;
        end else begin
          v6_dig_nxt = v6_dig_r + 1'b1;
        end
      end else if (tok.is_colon) begin
        if (v6_dig_r == 3'd0 || v6_colon_r == V6_LAST_COLON) begin
          v6_alive_nxt = 1'b0;
        end else begin
          v6_colon_nxt = v6_colon_r + 1'b1;
          v6_dig_nxt   = 3'd0;
        end
      end else begin
        v6_alive_nxt = 1'b0;
      end
    end

    if (v4_alive_nxt && v4_dot_nxt == V4_LAST_DOT && v4_dig_nxt != 2'd0) begin
      cls = CLASS_IPV4;
    end else if (v6_alive_nxt && v6_colon_nxt == V6_LAST_COLON && v6_dig_nxt != 3'd0) begin
      cls = CLASS_IPV6;
    end else begin
      cls = CLASS_NEITHER;
    end

    out_valid_nxt = out_valid_r & out_stall;
    out_class_nxt = out_class_r;
    if (pop && tok.last) begin
      out_valid_nxt = 1'b1;
      out_class_nxt = cls;
      // string done, back to the start state
      v4_alive_nxt = 1'b1;
      v4_dot_nxt   = 2'd0;
      v4_dig_nxt   = 2'd0;
      v4_oct_nxt   = 8'd0;
      v4_lz_nxt    = 1'b0;
      v6_alive_nxt = 1'b1;
      v6_colon_nxt = 3'd0;
      v6_dig_nxt   = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_alive_r  <= 1'b1;
      v4_dot_r    <= 2'd0;
      v4_dig_r    <= 2'd0;
      v4_oct_r    <= 8'd0;
      v4_lz_r     <= 1'b0;
      v6_alive_r  <= 1'b1;
      v6_colon_r  <= 3'd0;
      v6_dig_r    <= 3'd0;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      v4_alive_r  <= v4_alive_nxt;
      v4_dot_r    <= v4_dot_nxt;
      v4_dig_r    <= v4_dig_nxt;
      v4_oct_r    <= v4_oct_nxt;
      v4_lz_r     <= v4_lz_nxt;
      v6_alive_r  <= v6_alive_nxt;
      v6_colon_r  <= v6_colon_nxt;
      v6_dig_r    <= v6_dig_nxt;
      out_valid_r <= out_valid_nxt;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
  end

endmodule

// File: hdl/ip_address_text_classifier_top.sv
// ----------------------------------------------------------------------------
// ip_address_text_classifier_top
// classifies address text as ipv4, ipv6 or neither, one character per beat
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  -------------------------------------
//  in_      in   in_valid / in_stall  in_text_char[7:0], in_is_final
//  out_     out  out_valid/out_stall  out_address_class[1:0] (0 v4,1 v6,2 no)
//
//  one character beat per cycle sustained; the front classifies and queues,
//  the back updates both recognizers on one token per cycle
//  with the queue empty the final token is queued, then popped and registered
//  rst_n (sync, active low) empties the token queue and the result register
//  in_stall rises only when the four-entry token queue is full; the back
//  keeps draining non-final tokens while a result waits on out_stall
//
module ip_address_text_classifier_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_char,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_address_class
);
  import ipatc_pkg::*;

  // front to queue
  logic   push;
  token_t push_tok;
  logic   q_full;

  // queue to back
  logic   tok_valid;
  token_t tok;
  logic   pop;

  // character classification at the input edge
  ipatc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_char (in_text_char),
    .in_is_final  (in_is_final),
    .push         (push),
    .push_tok     (push_tok),
    .q_full       (q_full)
  );

  // token queue decouples input stalls from output stalls
  ipatc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  // recognizers and registered result
  ipatc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_valid         (tok_valid),
    .tok               (tok),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_address_class (out_address_class)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for ip_address_text_classifier_top: address strings go
// in one character beat at a time and every class result is checked against
// a typed-in class or a character-level model of the ipv4 and ipv6 recognizers
// ----------------------------------------------------------------------------
module tb;
  import ipatc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BEATS = 700;
  localparam int MODE_SPAN    = 90;   // beats per idling mode

  // ---------------------------------------------------------------------------
  // clock, reset and the block's pins (all driven known from time zero)
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_char = 8'h00;
  logic       in_is_final = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_address_class;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ip_address_text_classifier_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_char      (in_text_char),
    .in_is_final       (in_is_final),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_address_class (out_address_class)
  );

  // ---------------------------------------------------------------------------
  // recognizer model: both forms tracked in parallel, cleared on the final beat
  // ---------------------------------------------------------------------------
  typedef struct {
    logic       v4_ok;
    logic [1:0] dots;
    logic [1:0] dec_digits;
    logic [7:0] octet;
    logic       lead_zero;
    logic       v6_ok;
    logic [2:0] colons;
    logic [2:0] hex_digits;
  } addr_scan_t;

  addr_scan_t scan;
  logic [1:0] class_due[$];   // classes still owed by the block, oldest first
  int         err_count = 0;
  int         beats_sent = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic [7:0] text_buf[$];    // string under construction for send_text
  logic [1:0] want;

  task automatic scan_clear();
    scan.v4_ok      = 1'b1;
    scan.dots       = '0;
    scan.dec_digits = '0;
    scan.octet      = '0;
    scan.lead_zero  = 1'b0;
    scan.v6_ok      = 1'b1;
    scan.colons     = '0;
    scan.hex_digits = '0;
  endtask

  // advance the model by one character; cls is valid only on the final beat
  task automatic scan_char(input logic [7:0] c, input logic fin, output logic [1:0] cls);
    int  dval;
    int  next_val;
    bit  is_dec;
    bit  is_hex;
    is_dec = (c >= CH_ZERO && c <= CH_NINE);
    is_hex = is_dec || (c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F);
    cls = CLASS_NEITHER;

    // ipv4 side
    if (scan.v4_ok) begin
      if (is_dec) begin
        dval = int'(c - CH_ZERO);
        next_val = int'(scan.octet) * 10 + dval;
        if (scan.dec_digits >= V4_MAX_DIGITS || scan.lead_zero || next_val > V4_OCTET_MAX) begin
          scan.v4_ok = 1'b0;
        end else begin
          if (scan.dec_digits == 0 && dval == 0) scan.lead_zero = 1'b1;
          scan.octet      = next_val[7:0];
          scan.dec_digits = scan.dec_digits + 1'b1;
        end
      end else if (c == CH_DOT) begin
        if (scan.dec_digits == 0 || scan.dots >= V4_LAST_DOT) begin
          scan.v4_ok = 1'b0;
        end else begin
          scan.dots       = scan.dots + 1'b1;
          scan.dec_digits = '0;
          scan.octet      = '0;
          scan.lead_zero  = 1'b0;
        end
      end else begin
        scan.v4_ok = 1'b0;
      end
    end

    // ipv6 side
    if (scan.v6_ok) begin
      if (is_hex) begin
        if (scan.hex_digits >= V6_MAX_DIGITS) scan.v6_ok = 1'b0;
        else scan.hex_digits = scan.hex_digits + 1'b1;
      end else if (c == CH_COLON) begin
        if (scan.hex_digits == 0 || scan.colons >= V6_LAST_COLON) begin
          scan.v6_ok = 1'b0;
        end else begin
          scan.colons     = scan.colons + 1'b1;
          scan.hex_digits = '0;
        end
      end else begin
        scan.v6_ok = 1'b0;
      end
    end

    if (fin) begin
      if (scan.v4_ok && scan.dots == V4_LAST_DOT && scan.dec_digits != 0) cls = CLASS_IPV4;
      else if (scan.v6_ok && scan.colons == V6_LAST_COLON && scan.hex_digits != 0)
        cls = CLASS_IPV6;
      else cls = CLASS_NEITHER;
      scan_clear();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input side: optional idle gap, then hold the beat until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] c, input logic fin, input bit typed,
                           input logic [1:0] typed_cls);
    logic [1:0] cls;
    // caller sits at a falling edge here
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_char <= c;
    in_is_final  <= fin;
    do @(posedge clk); while (in_stall);
    scan_char(c, fin, cls);
    if (fin) class_due.push_back(typed ? typed_cls : cls);
    beats_sent++;
    @(negedge clk);
  endtask

  // whole string; the last character carries the final flag
  task automatic send_text(input bit typed, input logic [1:0] typed_cls);
    // idling mode follows the beat count: none, sender, receiver, both
    case ((beats_sent / MODE_SPAN) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
    foreach (text_buf[i]) send_beat(text_buf[i], i == text_buf.size() - 1, typed, typed_cls);
  endtask

  // ---------------------------------------------------------------------------
  // random string builders
  // ---------------------------------------------------------------------------
  task automatic put_decimal(input int v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v > 0);
    foreach (digs[i]) text_buf.push_back(digs[i]);
  endtask

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 16) return CH_LC_A + 8'(r - 10);
    return CH_UC_A + 8'(r - 16);
  endfunction

  task automatic put_octet();
    case ($urandom_range(0, 29))
      0: put_decimal(0);
      1: put_decimal(255);
      2: put_decimal($urandom_range(250, 255));
      3: begin                                   // leading zero
        text_buf.push_back(CH_ZERO);
        put_decimal($urandom_range(0, 99));
      end
      4: put_decimal($urandom_range(256, 999));  // octet too large
      5: put_decimal($urandom_range(1000, 9999)); // too many digits
      6: ;                                       // empty octet
      default: put_decimal($urandom_range(0, 255));
    endcase
  endtask

  task automatic put_group();
    int n;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 15) == 0) n = ($urandom_range(0, 1) == 0) ? 0 : 5;
    repeat (n) text_buf.push_back(pick_hex());
  endtask

  task automatic build_v4();
    int n;
    n = 4;
    if ($urandom_range(0, 9) == 0) n = ($urandom_range(0, 1) == 0) ? 3 : 5;
    for (int i = 0; i < n; i++) begin
      if (i != 0) text_buf.push_back(CH_DOT);
      put_octet();
    end
  endtask

  task automatic build_v6();
    int n;
    n = 8;
    if ($urandom_range(0, 9) == 0) n = ($urandom_range(0, 1) == 0) ? 7 : 9;
    for (int i = 0; i < n; i++) begin
      if (i != 0) text_buf.push_back(CH_COLON);
      put_group();
    end
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0, 1, 2: text_buf.push_back(8'($urandom_range(0, 255)));
        3: text_buf.push_back(CH_DOT);
        4: text_buf.push_back(CH_COLON);
        default: text_buf.push_back(pick_hex());
      endcase
    end
  endtask

  // change a string in one place
  task automatic mangle_text();
    int pos;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: text_buf[pos] = 8'($urandom_range(0, 255));
      1: text_buf[pos] = ($urandom_range(0, 1) == 0) ? CH_DOT : CH_COLON;
      2: if (text_buf.size() > 1) text_buf.delete(pos);
      default: text_buf.insert(pos, text_buf[pos]);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, check every taken beat against the oldest class
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (class_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected", out_address_class));
      end else begin
        want = class_due.pop_front();
        if (out_address_class !== want)
          report_mismatch($sformatf("address_class %0d, expected %0d", out_address_class, want));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL ip_address_text_classifier_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed strings: the edge forms, expected class typed in where obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    string      text;
    bit         typed;
    logic [1:0] cls;
  } text_row_t;

  text_row_t edge_rows[6];

  initial begin
    edge_rows = '{
      '{"\377",            1'b1, CLASS_NEITHER},  // top byte alone
      '{".",               1'b1, CLASS_NEITHER},  // lone dot
      '{":",               1'b1, CLASS_NEITHER},  // lone colon
      '{"0.0.0.0",         1'b1, CLASS_IPV4},     // shortest ipv4, lone zeros
      '{"a:0:0:0:0:0:0:F", 1'b1, CLASS_IPV6},     // shortest ipv6, both cases
      '{"01",              1'b0, CLASS_NEITHER}   // leading zero, left to the model
    };
    scan_clear();

    // reset held low from time zero, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (edge_rows[r]) begin
      text_buf.delete();
      for (int i = 0; i < edge_rows[r].text.len(); i++) text_buf.push_back(edge_rows[r].text[i]);
      send_text(edge_rows[r].typed, edge_rows[r].cls);
    end

    // random strings: mostly well-formed shapes, some broken, some noise
    while (beats_sent < RANDOM_BEATS) begin
      text_buf.delete();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:     build_v4();
        8, 9, 10, 11, 12, 13, 14:   build_v6();
        default:                    build_noise();
      endcase
      if (text_buf.size() == 0) text_buf.push_back(CH_DOT);
      if ($urandom_range(0, 3) == 0) mangle_text();
      send_text(1'b0, CLASS_NEITHER);
    end
    in_valid <= 1'b0;

    // let the last results come out, then a short quiet spell
    while (class_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS ip_address_text_classifier_top");
    end else begin
      $display("FAIL ip_address_text_classifier_top");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ipatc_pkg.sv
hdl/ipatc_front.sv
hdl/ipatc_queue.sv
hdl/ipatc_back.sv
hdl/ip_address_text_classifier_top.sv
tb/tb.sv
